/* hdl/traffic_light_controller_with_setup_defines.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef TRAFFIC_LIGHT_CONTROLLER_WITH_SETUP_DEFINES_SVH
`define TRAFFIC_LIGHT_CONTROLLER_WITH_SETUP_DEFINES_SVH
// implication checked on every clock unless in reset
`define TLC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tlc check failed");
// next-cycle implication
`define TLC_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tlc check failed");
`endif

/* hdl/tlc_pkg.sv */
// types and constants for the traffic light controller
// no dependencies
package tlc_pkg;
    localparam int unsigned CountW = 7;
    localparam int unsigned NumRegs = 6;

    typedef enum logic [3:0] {
        ST_START = 4'd0, ST_PH0 = 4'd1, ST_PH1 = 4'd2, ST_PH2 = 4'd3, ST_PH3 = 4'd4,
        ST_MODE1 = 4'd5, ST_MODE2 = 4'd6, ST_MODE3 = 4'd7, ST_MODE4 = 4'd8,
        ST_ADJUST = 4'd9, ST_COMMIT = 4'd10, ST_TIMEOUT = 4'd11
    } t_state;

    localparam logic [2:0] D_NSR = 3'd0;
    localparam logic [2:0] D_NSY = 3'd1;
    localparam logic [2:0] D_NSG = 3'd2;
    localparam logic [2:0] D_EWR = 3'd3;
    localparam logic [2:0] D_EWY = 3'd4;
    localparam logic [2:0] D_EWG = 3'd5;

    localparam logic [1:0] BT_RELEASED = 2'd0;
    localparam logic [1:0] BT_PRESSED = 2'd1;
    localparam logic [1:0] BT_HELD = 2'd2;

    typedef struct packed {
        logic       mode_button;
        logic       mode_button_held;
        logic       adjust_button;
        logic       adjust_button_held;
        logic       set_button;
        logic       set_button_held;
        logic       second_tick;
        logic       blink_tick;
        logic       timeout_tick;
        logic       repeat_tick;
    } t_tick;

    typedef struct packed {
        logic [1:0]        light_phase;
        logic [3:0]        controller_state;
        logic [2:0]        mode_shown;
        logic [CountW-1:0] ns_count;
        logic [CountW-1:0] ew_count;
        logic              blink_toggle;
        logic [3:0]        timer_restart;
    } t_result;
endpackage

/* hdl/traffic_light_controller_with_setup.sv */
// One loop tick per input beat; each accepted tick yields one result beat.
// The tick's decision is one pass of logic from the state registers into the
// output register, so a new tick is taken every clock as long as the output
// register is empty or being drained.
// Depends on tlc_pkg, tlc_regs and tlc_core.
module traffic_light_controller_with_setup #(
    parameter int unsigned COUNT_MAX = 99
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode_button, mode_button_held, adjust_button, adjust_button_held,
    // set_button, set_button_held, second_tick, blink_tick, timeout_tick,
    // repeat_tick, zero fill
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // light_phase, controller_state, mode_shown, ns_count, ew_count,
    // blink_toggle, timer_restart, zero fill
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    logic step;
    tlc_pkg::t_tick tick;
    tlc_pkg::t_result res, r_res;
    logic r_valid;
    logic [tlc_pkg::CountW-1:0] defaults [tlc_pkg::NumRegs];

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign step = s_axis_tvalid && s_axis_tready;
    assign tick = {s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[2], s_axis_tdata[3],
                   s_axis_tdata[4], s_axis_tdata[5], s_axis_tdata[6], s_axis_tdata[7],
                   s_axis_tdata[8], s_axis_tdata[9]};

    tlc_regs u_regs (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_defaults(defaults)
    );
    tlc_core #(.COUNT_MAX(COUNT_MAX)) u_core (
        .i_clk, .i_rst_n, .i_step(step), .i_tick(tick), .i_defaults(defaults),
        .o_result(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (step) r_res <= res;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = {4'd0, r_res.timer_restart, r_res.blink_toggle, r_res.ew_count,
                           r_res.ns_count, r_res.mode_shown, r_res.controller_state,
                           r_res.light_phase};
endmodule

/* hdl/tlc_core.sv */
// controller state and one-tick next-state logic
// depends on tlc_pkg
module tlc_core #(
    parameter int unsigned COUNT_MAX = 99
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  tlc_pkg::t_tick          i_tick,
    input  logic [tlc_pkg::CountW-1:0] i_defaults [tlc_pkg::NumRegs],
    output tlc_pkg::t_result        o_result
);
    localparam int unsigned W = tlc_pkg::CountW;
    localparam logic [W-1:0] CMax = W'(COUNT_MAX);

    tlc_pkg::t_state r_st, r_last, n_st, n_last;
    logic [1:0] r_held, n_held;
    logic [2:0] r_edit, n_edit;
    logic [W-1:0] r_ns, r_ew, r_nss, r_ews, n_ns, n_ew, n_nss, n_ews;
    logic [W-1:0] r_dur [tlc_pkg::NumRegs];
    logic [W-1:0] n_dur [tlc_pkg::NumRegs];
    logic [1:0] r_bt [3];
    logic [1:0] n_bt [3];

    function automatic logic [W-1:0] winc(input logic [W-1:0] v);
        winc = (v < CMax) ? v + W'(1) : W'(1);
    endfunction
    function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        sadd = (s > {1'b0, CMax}) ? CMax : s[W-1:0];
    endfunction
    function automatic logic [W-1:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
        ssub = (a > b) ? a - b : '0;
    endfunction

    // returns fresh press, updates tracker
    function automatic logic track(input logic [1:0] t, input logic lvl, input logic hld,
                                   output logic [1:0] nt);
        nt = t;
        track = 1'b0;
        if (t == tlc_pkg::BT_RELEASED) begin
            if (lvl) begin
                nt = tlc_pkg::BT_PRESSED;
                track = 1'b1;
            end
        end else if (!lvl) begin
            nt = tlc_pkg::BT_RELEASED;
        end else if (t == tlc_pkg::BT_PRESSED && hld) begin
            nt = tlc_pkg::BT_HELD;
        end
    endfunction

    always_comb begin
        logic [3:0] rs;
        logic tog, p;
        logic [1:0] nt, h, lp;
        logic [2:0] m;
        logic [W-1:0] v;
        n_st = r_st; n_last = r_last; n_held = r_held; n_edit = r_edit;
        n_ns = r_ns; n_ew = r_ew; n_nss = r_nss; n_ews = r_ews;
        n_dur = r_dur; n_bt = r_bt;
        rs = '0; tog = 1'b0; p = 1'b0; nt = '0; m = '0; v = '0; lp = '0;
        h = r_held;
        if (r_st >= tlc_pkg::ST_MODE1 && r_st <= tlc_pkg::ST_TIMEOUT && i_tick.blink_tick) begin
            tog = 1'b1; rs[0] = 1'b1;
        end
        if (r_st >= tlc_pkg::ST_MODE1 && r_st <= tlc_pkg::ST_ADJUST && i_tick.timeout_tick) begin
            n_last = n_st; n_st = tlc_pkg::ST_TIMEOUT;
        end
        // raise pass: m set below selects which count moves
        if (r_st == tlc_pkg::ST_START) begin
            if (r_last == tlc_pkg::ST_MODE1) n_dur = i_defaults;
            n_last = n_st; n_st = tlc_pkg::ST_PH0;
            n_ns = n_dur[tlc_pkg::D_NSG]; n_ew = n_dur[tlc_pkg::D_EWR];
            rs[1:0] = 2'b11;
        end else if (r_st >= tlc_pkg::ST_PH0 && r_st <= tlc_pkg::ST_PH3) begin
            if (i_tick.second_tick) begin
                n_ns = (r_ns != '0) ? r_ns - W'(1) : '0;
                n_ew = (r_ew != '0) ? r_ew - W'(1) : '0;
                n_nss = n_ns; n_ews = n_ew;
                if (n_ns == '0 || n_ew == '0) begin
                    n_held = 2'(r_st - tlc_pkg::ST_PH0);
                    n_last = n_st;
                    case (r_st)
                        tlc_pkg::ST_PH0: n_ns = r_dur[tlc_pkg::D_NSY];
                        tlc_pkg::ST_PH1: begin
                            n_ns = r_dur[tlc_pkg::D_NSR]; n_ew = r_dur[tlc_pkg::D_EWG];
                        end
                        tlc_pkg::ST_PH2: n_ew = r_dur[tlc_pkg::D_EWY];
                        default: begin
                            n_ns = r_dur[tlc_pkg::D_NSG]; n_ew = r_dur[tlc_pkg::D_EWR];
                        end
                    endcase
                    n_st = (r_st == tlc_pkg::ST_PH3) ? tlc_pkg::ST_PH0
                                                     : tlc_pkg::t_state'(r_st + 4'd1);
                end
                rs[1] = 1'b1;
            end
            p = track(r_bt[0], i_tick.mode_button, i_tick.mode_button_held, nt);
            n_bt[0] = nt;
            if (p) begin
                n_last = n_st;
                n_held = 2'(n_st - tlc_pkg::ST_PH0);
                n_st = tlc_pkg::ST_MODE1; n_edit = 3'd1; rs[2] = 1'b1;
            end
        end else if (r_st >= tlc_pkg::ST_MODE1 && r_st <= tlc_pkg::ST_MODE4) begin
            p = track(r_bt[0], i_tick.mode_button, i_tick.mode_button_held, nt);
            n_bt[0] = nt;
            if (p) begin
                n_last = n_st;
                n_st = (r_st == tlc_pkg::ST_MODE4) ? tlc_pkg::ST_MODE1
                                                   : tlc_pkg::t_state'(r_st + 4'd1);
                n_edit = 3'(n_st - tlc_pkg::ST_MODE1 + 4'd1);
                rs[2] = 1'b1;
            end
            if (r_st == tlc_pkg::ST_MODE1) begin
                p = track(r_bt[2], i_tick.set_button, i_tick.set_button_held, nt);
                n_bt[2] = nt;
                if (p) begin
                    n_last = n_st; n_st = tlc_pkg::ST_START; n_edit = '0;
                end
            end else begin
                p = track(r_bt[1], i_tick.adjust_button, i_tick.adjust_button_held, nt);
                n_bt[1] = nt;
                if (p) begin
                    m = 3'(r_st - tlc_pkg::ST_MODE1 + 4'd1);
                    n_last = n_st; n_st = tlc_pkg::ST_ADJUST; rs[3] = 1'b1;
                end
            end
        end else if (r_st == tlc_pkg::ST_ADJUST) begin
            if (r_bt[1] == tlc_pkg::BT_RELEASED) begin
                if (i_tick.adjust_button) begin
                    m = r_edit;
                    if (i_tick.repeat_tick) rs[3:2] = 2'b11;
                    n_bt[1] = tlc_pkg::BT_PRESSED;
                end
            end else if (!i_tick.adjust_button) begin
                n_bt[1] = tlc_pkg::BT_RELEASED;
            end else begin
                if (i_tick.repeat_tick) begin
                    m = r_edit; rs[3:2] = 2'b11;
                end
                if (r_bt[1] == tlc_pkg::BT_PRESSED && i_tick.adjust_button_held)
                    n_bt[1] = tlc_pkg::BT_HELD;
            end
            p = track(r_bt[2], i_tick.set_button, i_tick.set_button_held, nt);
            n_bt[2] = nt;
            if (p) begin
                n_last = n_st; n_st = tlc_pkg::ST_COMMIT;
            end
        end else if (r_st == tlc_pkg::ST_TIMEOUT) begin
            n_last = n_st; n_st = tlc_pkg::ST_COMMIT;
        end else if (r_st == tlc_pkg::ST_COMMIT) begin
            if (i_tick.second_tick) rs[1] = 1'b1;
            if (r_last == tlc_pkg::ST_TIMEOUT) begin
                n_ns = r_nss; n_ew = r_ews;
            end else if (r_last == tlc_pkg::ST_ADJUST) begin
                case (r_edit)
                    3'd2: begin
                        v = (h >= 2'd2) ? r_ns : r_ew;
                        n_dur[tlc_pkg::D_NSR] = v; n_dur[tlc_pkg::D_EWR] = v;
                        if (v != r_nss) begin
                            n_dur[tlc_pkg::D_NSG] = ssub(v, r_dur[tlc_pkg::D_NSY]);
                            n_dur[tlc_pkg::D_EWG] = ssub(v, r_dur[tlc_pkg::D_EWY]);
                        end
                    end
                    3'd3: begin
                        if (h[0]) begin
                            v = (h == 2'd1) ? r_ns : r_ew;
                            n_dur[tlc_pkg::D_NSY] = v; n_dur[tlc_pkg::D_EWY] = v;
                        end
                        if (n_dur[tlc_pkg::D_NSY] != r_nss) begin
                            n_dur[tlc_pkg::D_NSR] = sadd(n_dur[tlc_pkg::D_NSY],
                                                         r_dur[tlc_pkg::D_NSG]);
                            n_dur[tlc_pkg::D_EWR] = sadd(n_dur[tlc_pkg::D_EWY],
                                                         r_dur[tlc_pkg::D_EWG]);
                        end
                    end
                    3'd4: begin
                        if (!h[0]) begin
                            v = (h == 2'd0) ? r_ns : r_ew;
                            n_dur[tlc_pkg::D_NSG] = v; n_dur[tlc_pkg::D_EWG] = v;
                        end
                        if (n_dur[tlc_pkg::D_NSG] != r_nss) begin
                            n_dur[tlc_pkg::D_NSR] = sadd(r_dur[tlc_pkg::D_NSY],
                                                         n_dur[tlc_pkg::D_NSG]);
                            n_dur[tlc_pkg::D_EWR] = sadd(r_dur[tlc_pkg::D_EWY],
                                                         n_dur[tlc_pkg::D_EWG]);
                        end
                    end
                    default: ;
                endcase
            end
            n_last = n_st;
            n_st = tlc_pkg::t_state'(4'(tlc_pkg::ST_PH0) + {2'b00, r_held});
            n_edit = '0;
        end
        // time raise for adjust presses, held phase is stable in setup states
        case (m)
            3'd2: begin
                if (h >= 2'd2) n_ns = winc(r_ns);
                if (h <= 2'd1) n_ew = winc(r_ew);
            end
            3'd3: begin
                if (h == 2'd1) n_ns = winc(r_ns);
                if (h == 2'd3) n_ew = winc(r_ew);
            end
            3'd4: begin
                if (h == 2'd0) n_ns = winc(r_ns);
                if (h == 2'd2) n_ew = winc(r_ew);
            end
            default: ;
        endcase
        if (n_st >= tlc_pkg::ST_PH0 && n_st <= tlc_pkg::ST_PH3)
            lp = 2'(n_st - tlc_pkg::ST_PH0);
        else if (n_st == tlc_pkg::ST_START)
            lp = '0;
        else
            lp = n_held;
        o_result.light_phase = lp;
        o_result.controller_state = n_st;
        o_result.mode_shown = n_edit;
        o_result.ns_count = n_ns;
        o_result.ew_count = n_ew;
        o_result.blink_toggle = tog;
        o_result.timer_restart = rs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tlc_pkg::ST_START; r_last <= tlc_pkg::ST_START;
            r_held <= '0; r_edit <= '0;
            r_ns <= '0; r_ew <= '0; r_nss <= '0; r_ews <= '0;
            r_dur[0] <= W'(5); r_dur[1] <= W'(2); r_dur[2] <= W'(3);
            r_dur[3] <= W'(5); r_dur[4] <= W'(2); r_dur[5] <= W'(3);
            r_bt[0] <= tlc_pkg::BT_RELEASED; r_bt[1] <= tlc_pkg::BT_RELEASED;
            r_bt[2] <= tlc_pkg::BT_RELEASED;
        end else if (i_step) begin
            r_st <= n_st; r_last <= n_last; r_held <= n_held; r_edit <= n_edit;
            r_ns <= n_ns; r_ew <= n_ew; r_nss <= n_nss; r_ews <= n_ews;
            r_dur <= n_dur; r_bt <= n_bt;
        end
    end
endmodule

/* hdl/tlc_regs.sv */
// default duration registers written through the setup port
// depends on tlc_pkg
module tlc_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [tlc_pkg::CountW-1:0] i_cfg_data,
    output logic [tlc_pkg::CountW-1:0] o_defaults [tlc_pkg::NumRegs]
);
    logic [tlc_pkg::CountW-1:0] r_regs [tlc_pkg::NumRegs];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[0] <= 7'd5; r_regs[1] <= 7'd2; r_regs[2] <= 7'd3;
            r_regs[3] <= 7'd5; r_regs[4] <= 7'd2; r_regs[5] <= 7'd3;
        end else if (i_cfg_we && i_cfg_index < 3'(tlc_pkg::NumRegs)) begin
            r_regs[i_cfg_index] <= i_cfg_data;
        end
    end
    assign o_defaults = r_regs;
endmodule

/* hdl/tlc_checker.sv */
// port-level checks for the traffic light controller, bound to the top level
// depends on traffic_light_controller_with_setup_defines.svh
`include "traffic_light_controller_with_setup_defines.svh"
module tlc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    `TLC_ASSERT_NXT(a_beat_out, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    `TLC_ASSERT_IMP(a_ready, i_clk, i_rst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready)
    `TLC_ASSERT_IMP(a_state_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[5:2] <= 4'd11)
    `TLC_ASSERT_IMP(a_mode_zero, i_clk, i_rst_n,
                    m_axis_tvalid && m_axis_tdata[5:2] <= 4'd4, m_axis_tdata[8:6] == 3'd0)
endmodule

bind traffic_light_controller_with_setup tlc_checker u_tlc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
